FILE: hdl/dns_response_address_parser_top_macros.svh
// assertion macros for the dns response address parser
// used by dns_response_address_parser_top; expects clk and rst_n in scope
`ifndef DNS_RESPONSE_ADDRESS_PARSER_TOP_MACROS_SVH
`define DNS_RESPONSE_ADDRESS_PARSER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define DNSP_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DNSP_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/dnsp_pkg.sv
// types and constants for the dns response address parser
// no dependencies; imported by dnsp_step, dns_response_address_parser_top and the testbench
package dnsp_pkg;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_QNAME  = 3'd1,
        PH_QTAIL  = 3'd2,
        PH_ANAME  = 3'd3,
        PH_AFIXED = 3'd4,
        PH_RDATA  = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

    localparam logic [3:0]  HEADER_LAST    = 4'd11;
    localparam logic [3:0]  HDR_QD_HI      = 4'd4;
    localparam logic [3:0]  HDR_QD_LO      = 4'd5;
    localparam logic [3:0]  HDR_AN_HI      = 4'd6;
    localparam logic [3:0]  HDR_AN_LO      = 4'd7;
    localparam logic [7:0]  PTR_MASK       = 8'hC0;
    localparam logic [15:0] QTAIL_BYTES    = 16'd4;
    localparam logic [15:0] FIXED_BYTES    = 16'd10;
    localparam logic [15:0] FIXED_PTR      = 16'd11;
    localparam logic [15:0] ADDR_RDLEN     = 16'd4;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] address;
        logic        address_valid;
        logic        datagram_end;
        logic [15:0] addresses_found;
        logic        truncated;
    } out_beat_t;

    typedef struct packed {
        phase_t      phase;
        logic [3:0]  header_index;
        logic [15:0] questions_left;
        logic [15:0] answers_left;
        logic [7:0]  label_left;
        logic [15:0] skip_left;
        logic [15:0] rdata_length;
        logic [31:0] address_shift;
        logic [15:0] found_count;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:          PH_HEADER,
        header_index:   4'd0,
        questions_left: 16'd0,
        answers_left:   16'd0,
        label_left:     8'd0,
        skip_left:      16'd0,
        rdata_length:   16'd0,
        address_shift:  32'd0,
        found_count:    16'd0
    };

endpackage

FILE: hdl/dnsp_step.sv
// one-byte parse step: next parser state and the result for that byte
// depends on dnsp_pkg
module dnsp_step import dnsp_pkg::*;
(
    input  parse_state_t cur,
    input  in_beat_t     beat,
    output parse_state_t nxt,
    output out_beat_t    res,
    output logic         has_result
);

    function automatic phase_t next_section(logic [15:0] q, logic [15:0] a);
        phase_t p;
        p = PH_DONE;
        if (q != 16'd0)
            p = PH_QNAME;
        else if (a != 16'd0)
            p = PH_ANAME;
        return p;
    endfunction

    always_comb
    begin
        logic        valid;
        logic [7:0]  b;
        logic [15:0] skip_dec;
        logic [15:0] len_shift;
        logic [15:0] ans_dec;
        b         = beat.data_byte;
        valid     = 1'b0;
        nxt       = cur;
        skip_dec  = cur.skip_left - 16'd1;
        len_shift = {cur.rdata_length[7:0], b};
        ans_dec   = cur.answers_left - 16'd1;

        unique case (cur.phase)
            PH_HEADER:
            begin
                if (cur.header_index == HDR_QD_HI || cur.header_index == HDR_QD_LO)
                    nxt.questions_left = {cur.questions_left[7:0], b};
                else if (cur.header_index == HDR_AN_HI || cur.header_index == HDR_AN_LO)
                    nxt.answers_left = {cur.answers_left[7:0], b};
                if (cur.header_index >= HEADER_LAST)
                begin
                    nxt.header_index = 4'd0;
                    nxt.label_left   = 8'd0;
                    nxt.phase        = next_section(nxt.questions_left, nxt.answers_left);
                end
                else
                begin
                    nxt.header_index = cur.header_index + 4'd1;
                end
            end
            PH_QNAME:
            begin
                if (cur.label_left != 8'd0)
                    nxt.label_left = cur.label_left - 8'd1;
                else if (b == 8'd0)
                begin
                    nxt.phase     = PH_QTAIL;
                    nxt.skip_left = QTAIL_BYTES;
                end
                else
                    nxt.label_left = b;
            end
            PH_QTAIL:
            begin
                nxt.skip_left = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    nxt.questions_left = cur.questions_left - 16'd1;
                    nxt.label_left     = 8'd0;
                    nxt.phase = next_section(nxt.questions_left, cur.answers_left);
                end
            end
            PH_ANAME:
            begin
                if (cur.label_left != 8'd0)
                    nxt.label_left = cur.label_left - 8'd1;
                else if ((b & PTR_MASK) != 8'd0)
                begin
                    // compression pointer: second pointer byte plus fixed fields
                    nxt.phase        = PH_AFIXED;
                    nxt.skip_left    = FIXED_PTR;
                    nxt.rdata_length = 16'd0;
                end
                else if (b == 8'd0)
                begin
                    nxt.phase        = PH_AFIXED;
                    nxt.skip_left    = FIXED_BYTES;
                    nxt.rdata_length = 16'd0;
                end
                else
                    nxt.label_left = b;
            end
            PH_AFIXED:
            begin
                nxt.rdata_length = len_shift;
                nxt.skip_left    = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    if (len_shift == 16'd0)
                    begin
                        nxt.answers_left = ans_dec;
                        nxt.label_left   = 8'd0;
                        nxt.phase        = next_section(cur.questions_left, ans_dec);
                    end
                    else
                    begin
                        nxt.phase         = PH_RDATA;
                        nxt.skip_left     = len_shift;
                        nxt.address_shift = 32'd0;
                    end
                end
            end
            PH_RDATA:
            begin
                nxt.address_shift = {cur.address_shift[23:0], b};
                nxt.skip_left     = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    if (cur.rdata_length == ADDR_RDLEN)
                    begin
                        valid = 1'b1;
                        if (cur.found_count != COUNT_MAX)
                            nxt.found_count = cur.found_count + 16'd1;
                    end
                    nxt.answers_left = ans_dec;
                    nxt.label_left   = 8'd0;
                    nxt.phase        = next_section(cur.questions_left, ans_dec);
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase

        has_result          = valid || beat.last_byte;
        res.address         = valid ? nxt.address_shift : 32'd0;
        res.address_valid   = valid;
        res.datagram_end    = beat.last_byte;
        res.addresses_found = nxt.found_count;
        res.truncated       = beat.last_byte && (nxt.phase != PH_DONE);
    end

endmodule

FILE: hdl/dns_response_address_parser_top.sv
// top level of the dns response address parser: input stage, parse step, result stage
// depends on dnsp_pkg, dnsp_step and dns_response_address_parser_top_macros.svh
//
// usage
//   in channel: one datagram byte per beat (in_data.data_byte), with
//   in_data.last_byte set on the final byte of each datagram
//   out channel: a beat whenever an answer record with 4-byte rdata
//   completes (address_valid) and on the final byte (datagram_end, with
//   truncated set if the questions or answers were not all parsed)
//   path: a byte accepted is held in the input register, then the parse
//   step feeds its result into the result register
//   throughput: one byte per cycle; the parse step is combinational
//   counter and compare logic, so nothing limits the rate but the stall
//   bytes that give no result are dropped after the parse step
//   reset: parser returns to the header phase, both stages empty
//   at the final byte the parser state returns to reset, so the next byte
//   starts a new datagram
//   receiver stall: the result register holds; in_stall rises only when
//   the input register is full and its byte cannot move on
`include "dns_response_address_parser_top_macros.svh"

module dns_response_address_parser_top import dnsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_data
);

    // input stage
    logic         s1_valid_reg;
    logic         s1_valid_next;
    in_beat_t     s1_data_reg;

    // result stage
    logic         out_valid_reg;
    logic         out_valid_next;
    out_beat_t    out_data_reg;

    // parser state
    parse_state_t state_reg;
    parse_state_t state_next;

    parse_state_t step_state;
    out_beat_t    step_res;
    logic         step_has_result;

    logic         in_take;
    logic         s1_adv;

    dnsp_step u_step
    (
        .cur        (state_reg),
        .beat       (s1_data_reg),
        .nxt        (step_state),
        .res        (step_res),
        .has_result (step_has_result)
    );

    // the byte in the input stage moves on whenever the result register
    // is free or being emptied this cycle
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv && step_has_result)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_comb
    begin
        state_next = state_reg;
        if (s1_adv)
            // end of datagram puts the parser back to reset
            state_next = s1_data_reg.last_byte ? STATE_RESET : step_state;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_data_reg <= in_data;
        if (s1_adv && step_has_result)
            out_data_reg <= step_res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    `DNSP_ASSERT_IMP(a_stall_cause, in_stall, s1_valid_reg && out_valid_reg && out_stall,
        "input stalled without a held result")
    `DNSP_ASSERT_IMP(a_trunc_at_end, out_valid && out_data.truncated, out_data.datagram_end,
        "truncation reported before the end of a datagram")
    `DNSP_ASSERT_IMP(a_addr_zero, out_valid && !out_data.address_valid,
        out_data.address == 32'd0, "address nonzero on a result without an address")
    `DNSP_ASSERT_NXT(a_end_resets, s1_adv && s1_data_reg.last_byte,
        state_reg.phase == PH_HEADER && state_reg.found_count == 16'd0,
        "parser state not cleared after the final byte")

endmodule

FILE: tb/tb_dns_response_address_parser_top.sv
// self-checking testbench for dns_response_address_parser_top
// depends on dnsp_pkg and the parser rtl; drives whole dns datagrams byte by byte
// and checks every out beat against a cycle-free model of the parse
module tb_dns_response_address_parser_top;
    import dnsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // generous bound: the random and steady bytes plus the directed tests, each byte
    // with a random sender gap and receiver stall on top of the pipeline
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_BYTES = 700;
    localparam int unsigned STEADY_BYTES = 300;
    localparam int unsigned DRAIN_CYCLES = 16;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_beat_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_beat_t out_data;

    // parser model state and the results it still owes
    parse_state_t parser;
    out_beat_t    expected_results[$];

    // bytes of the datagram being built
    logic [7:0] datagram_bytes[$];

    // idling switches for the two sides
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;

    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    int unsigned datagrams_sent = 0;
    int unsigned results_checked = 0;
    int unsigned addresses_seen = 0;
    int unsigned truncated_seen = 0;

    dns_response_address_parser_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed", cycle_count,
                     expected_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // parse model
    // ------------------------------------------------------------------

    // pick the next section once a header, question or answer is done
    function automatic void advance_section();
        parser.label_left = 8'd0;
        if (parser.questions_left != 16'd0)
            parser.phase = PH_QNAME;
        else if (parser.answers_left != 16'd0)
            parser.phase = PH_ANAME;
        else
            parser.phase = PH_DONE;
    endfunction

    function automatic void retire_answer();
        parser.answers_left = parser.answers_left - 16'd1;
        advance_section();
    endfunction

    // one byte through the parser; returns 1 when the byte gives an out beat
    function automatic bit parse_byte(input in_beat_t beat, output out_beat_t res);
        logic [7:0]  b;
        logic [31:0] addr;
        bit          hit;
        b    = beat.data_byte;
        addr = 32'd0;
        hit  = 1'b0;
        case (parser.phase)
            PH_HEADER:
            begin
                // counts sit at offsets 4..5 (questions) and 6..7 (answers)
                if (parser.header_index == 4'd4 || parser.header_index == 4'd5)
                    parser.questions_left = {parser.questions_left[7:0], b};
                else if (parser.header_index == 4'd6 || parser.header_index == 4'd7)
                    parser.answers_left = {parser.answers_left[7:0], b};
                if (parser.header_index >= 4'd11)
                begin
                    parser.header_index = 4'd0;
                    advance_section();
                end
                else
                begin
                    parser.header_index = parser.header_index + 4'd1;
                end
            end
            PH_QNAME:
            begin
                // no pointer test in question names
                if (parser.label_left != 8'd0)
                    parser.label_left = parser.label_left - 8'd1;
                else if (b == 8'd0)
                begin
                    parser.phase     = PH_QTAIL;
                    parser.skip_left = 16'd4;
                end
                else
                begin
                    parser.label_left = b;
                end
            end
            PH_QTAIL:
            begin
                parser.skip_left = parser.skip_left - 16'd1;
                if (parser.skip_left == 16'd0)
                begin
                    parser.questions_left = parser.questions_left - 16'd1;
                    advance_section();
                end
            end
            PH_ANAME:
            begin
                if (parser.label_left != 8'd0)
                    parser.label_left = parser.label_left - 8'd1;
                else if ((b & 8'hC0) != 8'd0)
                begin
                    // pointer: one more pointer byte, 8 fixed bytes, 2 length bytes
                    parser.phase        = PH_AFIXED;
                    parser.skip_left    = 16'd11;
                    parser.rdata_length = 16'd0;
                end
                else if (b == 8'd0)
                begin
                    parser.phase        = PH_AFIXED;
                    parser.skip_left    = 16'd10;
                    parser.rdata_length = 16'd0;
                end
                else
                begin
                    parser.label_left = b;
                end
            end
            PH_AFIXED:
            begin
                parser.rdata_length = {parser.rdata_length[7:0], b};
                parser.skip_left    = parser.skip_left - 16'd1;
                if (parser.skip_left == 16'd0)
                begin
                    if (parser.rdata_length == 16'd0)
                        retire_answer();
                    else
                    begin
                        parser.phase         = PH_RDATA;
                        parser.skip_left     = parser.rdata_length;
                        parser.address_shift = 32'd0;
                    end
                end
            end
            PH_RDATA:
            begin
                parser.address_shift = {parser.address_shift[23:0], b};
                parser.skip_left     = parser.skip_left - 16'd1;
                if (parser.skip_left == 16'd0)
                begin
                    if (parser.rdata_length == 16'd4)
                    begin
                        hit  = 1'b1;
                        addr = parser.address_shift;
                        if (parser.found_count != 16'hFFFF)
                            parser.found_count = parser.found_count + 16'd1;
                    end
                    retire_answer();
                end
            end
            default:
            begin
                // done: trailing sections are ignored
            end
        endcase

        res.address         = addr;
        res.address_valid   = hit;
        res.datagram_end    = beat.last_byte;
        res.addresses_found = parser.found_count;
        res.truncated       = beat.last_byte && (parser.phase != PH_DONE);
        if (beat.last_byte)
            parser = STATE_RESET;
        return hit || beat.last_byte;
    endfunction

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    // one in beat; stall is sampled at the falling edge, where it is stable
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        in_beat_t  beat;
        out_beat_t res;
        bit        taken;
        beat.data_byte = value;
        beat.last_byte = is_last;
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            if (taken)
            begin
                if (parse_byte(beat, res))
                    expected_results.push_back(res);
            end
            @(posedge clk);
        end
        while (!taken);
        bytes_sent++;
    endtask

    // send the built datagram, or only its first keep bytes when keep is nonzero
    task automatic send_datagram(input int unsigned keep);
        int unsigned n;
        n = (keep == 0 || keep > datagram_bytes.size()) ? datagram_bytes.size() : keep;
        for (int unsigned i = 0; i < n; i++)
            send_byte(datagram_bytes[i], i == n - 1);
        datagrams_sent++;
        datagram_bytes.delete();
    endtask

    // receiver stall bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_idle_en && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %0h actual %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_result(input out_beat_t got);
        out_beat_t want;
        if (expected_results.size() == 0)
        begin
            $display("%0t ns: out beat %0h arrived with nothing expected", $time, got);
            mismatches++;
        end
        else
        begin
            want = expected_results.pop_front();
            results_checked++;
            if (want.address_valid)
                addresses_seen++;
            if (want.truncated)
                truncated_seen++;
            compare_field("address", want.address, got.address);
            compare_field("address_valid", 32'(want.address_valid),
                          32'(got.address_valid));
            compare_field("datagram_end", 32'(want.datagram_end), 32'(got.datagram_end));
            compare_field("addresses_found", 32'(want.addresses_found),
                          32'(got.addresses_found));
            compare_field("truncated", 32'(want.truncated), 32'(got.truncated));
        end
    endtask

    // out beats are taken at the falling edge before the accepting rising edge
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_result(out_data);
    end

    // ------------------------------------------------------------------
    // datagram builders
    // ------------------------------------------------------------------

    task automatic push_random(input int unsigned count);
        repeat (count) datagram_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_header(input logic [15:0] qd, input logic [15:0] an);
        push_random(4);
        datagram_bytes.push_back(qd[15:8]);
        datagram_bytes.push_back(qd[7:0]);
        datagram_bytes.push_back(an[15:8]);
        datagram_bytes.push_back(an[7:0]);
        push_random(4);
    endtask

    // label lengths stay below 0x40 so answer names never look like pointers
    task automatic add_labels(input int unsigned count);
        int unsigned len;
        repeat (count)
        begin
            len = ($urandom_range(0, 15) == 0) ? 63 : $urandom_range(1, 8);
            datagram_bytes.push_back(8'(len));
            push_random(len);
        end
    endtask

    task automatic add_question();
        add_labels($urandom_range(0, 3));
        datagram_bytes.push_back(8'h00);
        push_random(4);
    endtask

    // answer with a pointer-ended or root-ended owner name; ptr_tag gives the
    // top two bits of the pointer byte, any nonzero value ends the name
    task automatic add_answer(input bit use_pointer, input logic [1:0] ptr_tag,
                              input int unsigned rdlen, input logic [31:0] addr);
        add_labels($urandom_range(0, 2));
        if (use_pointer)
        begin
            datagram_bytes.push_back({ptr_tag, 6'($urandom_range(0, 63))});
            push_random(1);
        end
        else
        begin
            datagram_bytes.push_back(8'h00);
        end
        push_random(8);
        datagram_bytes.push_back(8'(rdlen >> 8));
        datagram_bytes.push_back(8'(rdlen));
        if (rdlen == 4)
        begin
            for (int i = 3; i >= 0; i--)
                datagram_bytes.push_back(addr[8*i +: 8]);
        end
        else
        begin
            push_random(rdlen);
        end
    endtask

    function automatic int unsigned pick_rdata_length();
        int unsigned r;
        r = $urandom_range(0, 10);
        if (r < 6)
            return 4;
        else if (r == 6)
            return 0;
        else if (r == 7)
            return 16;
        else if (r == 8)
            return $urandom_range(1, 3);
        else if (r == 9)
            return $urandom_range(5, 12);
        return 256 + $urandom_range(0, 8);
    endfunction

    // mostly well-formed responses with random content; some cut short,
    // some with one corrupted byte, some plain noise
    task automatic random_datagram();
        int unsigned shape;
        int unsigned qd;
        int unsigned an;
        int unsigned keep;
        int unsigned pos;
        shape = $urandom_range(0, 19);
        keep  = 0;
        if (shape == 0)
        begin
            push_random($urandom_range(1, 40));
        end
        else
        begin
            qd = $urandom_range(0, 2);
            an = $urandom_range(0, 4);
            add_header(16'(qd), 16'(an));
            repeat (qd) add_question();
            repeat (an)
                add_answer(1'($urandom_range(0, 1)), 2'($urandom_range(1, 3)),
                           pick_rdata_length(), $urandom());
            push_random($urandom_range(0, 4));
            if (shape <= 2)
                keep = $urandom_range(1, datagram_bytes.size());
            else if (shape == 3)
            begin
                pos = $urandom_range(0, datagram_bytes.size() - 1);
                datagram_bytes[pos] = 8'($urandom_range(0, 255));
            end
        end
        send_datagram(keep);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // zero counts: done right after the header, trailing bytes ignored
    task automatic test_zero_counts();
        repeat (12) datagram_bytes.push_back(8'h00);
        send_datagram(0);
        add_header(16'd0, 16'd0);
        datagram_bytes.push_back(8'hFF);
        datagram_bytes.push_back(8'h00);
        datagram_bytes.push_back(8'hC0);
        send_datagram(0);
    endtask

    // all-ones header claims 65535 of each; a lone byte ends inside the header
    task automatic test_header_extremes();
        repeat (14) datagram_bytes.push_back(8'hFF);
        send_datagram(0);
        datagram_bytes.push_back(8'h00);
        send_datagram(0);
    endtask

    // two a records, the last rdata byte also being the final byte
    task automatic test_address_records();
        add_header(16'd1, 16'd2);
        add_question();
        add_answer(1'b1, 2'b11, 4, 32'hFFFF_FFFF);
        add_answer(1'b0, 2'b00, 4, 32'h0000_0000);
        send_datagram(0);
    endtask

    // zero, long and odd rdata lengths, pointer tags 01 and 10
    task automatic test_rdata_lengths();
        add_header(16'd0, 16'd4);
        add_answer(1'b1, 2'b11, 0, 32'd0);
        add_answer(1'b0, 2'b00, 16, 32'd0);
        add_answer(1'b1, 2'b01, 4, 32'hC0A8_0001);
        add_answer(1'b1, 2'b10, 1, 32'd0);
        push_random(2);
        send_datagram(0);
    endtask

    // a 0xc0 byte in a question name is a 192-byte label, not a pointer
    task automatic test_question_label_rule();
        add_header(16'd1, 16'd1);
        datagram_bytes.push_back(8'hC0);
        push_random(192);
        datagram_bytes.push_back(8'h00);
        push_random(4);
        add_answer(1'b1, 2'b11, 4, 32'h0A01_0203);
        send_datagram(0);
    endtask

    // final byte mid rdata, then mid question name
    task automatic test_truncation();
        add_header(16'd0, 16'd1);
        add_answer(1'b1, 2'b11, 4, 32'h1234_5678);
        send_datagram(datagram_bytes.size() - 2);
        add_header(16'd1, 16'd0);
        add_labels(2);
        send_datagram(13);
    endtask

    task automatic test_random_datagrams();
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
            random_datagram();
    endtask

    // back to back beats with the receiver always ready
    task automatic test_steady_flow();
        int unsigned start;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        start = bytes_sent;
        while (bytes_sent - start < STEADY_BYTES)
            random_datagram();
    endtask

    initial
    begin
        parser = STATE_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_counts();
        test_header_extremes();
        test_address_records();
        test_rdata_lengths();
        test_question_label_rule();
        test_truncation();
        test_random_datagrams();
        test_steady_flow();
        in_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d bytes in %0d datagrams, %0d out beats checked",
                 bytes_sent, datagrams_sent, results_checked);
        $display("of which %0d addresses and %0d truncated ends, %0d mismatches",
                 addresses_seen, truncated_seen, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/dnsp_pkg.sv
hdl/dnsp_step.sv
hdl/dns_response_address_parser_top.sv
tb/tb_dns_response_address_parser_top.sv
